>>> rtl/core/aabbfc_pkg.sv
package aabbfc_pkg;

	localparam int NORM_W = 16;
	localparam int OFFS_W = 40;
	localparam int IDX_W  = 3;

	// request kinds carried on req_type
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TEST = 1'b1;

	typedef struct packed {
		logic signed [OFFS_W-1:0] offset;
		logic signed [NORM_W-1:0] nz;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nx;
	} plane_t;

endpackage

>>> rtl/core/aabb_frustum_cull_top.sv
// Box culling against a stored set of clipping planes (positive-vertex test).
//
// Input channel (in_valid / in_stall): each request is either a plane load
// (req_type 0) or a box test (req_type 1). A load writes plane_index of the
// store at the edge it is accepted and gives no result; an index at or above
// NUM_PLANES is dropped. A test gives exactly one result on the output
// channel (out_valid / out_stall) with visible = 0 when the box lies wholly
// outside some plane.
//
// A test passes the input register, the product register and the result
// register in that order. Throughput is one request per cycle while in_stall
// is low; the three corner products of every plane are formed in
// parallel, one set of multipliers per plane. A load issued right after a
// test never affects that test, and a test always sees every earlier load.
//
// Reset clears the plane store to all zero, so planes never loaded always
// pass, and empties the pipeline. When the receiver stalls, the result
// register holds; bubbles ahead of it still fill, and in_stall rises only
// once every stage holds a test.
module aabb_frustum_cull_top #(
	parameter int NUM_PLANES = 6,
	parameter int COORD_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic [aabbfc_pkg::IDX_W-1:0]         plane_index,
	input  logic signed [aabbfc_pkg::NORM_W-1:0] plane_nx,
	input  logic signed [aabbfc_pkg::NORM_W-1:0] plane_ny,
	input  logic signed [aabbfc_pkg::NORM_W-1:0] plane_nz,
	input  logic signed [aabbfc_pkg::OFFS_W-1:0] plane_offset,
	input  logic signed [COORD_BITS-1:0]         box_min_x,
	input  logic signed [COORD_BITS-1:0]         box_min_y,
	input  logic signed [COORD_BITS-1:0]         box_min_z,
	input  logic signed [COORD_BITS-1:0]         box_max_x,
	input  logic signed [COORD_BITS-1:0]         box_max_y,
	input  logic signed [COORD_BITS-1:0]         box_max_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 visible
);
	import aabbfc_pkg::*;

	logic in_acc;
	logic load_wr;
	plane_t wr_plane;
	plane_t planes [NUM_PLANES];
	logic [NUM_PLANES-1:0] outside;

	logic s1_valid_s1, s2_valid_s2, out_valid_q, visible_q;
	logic s1_adv, s2_adv, out_adv;
	logic signed [COORD_BITS-1:0] min_x_s1, min_y_s1, min_z_s1;
	logic signed [COORD_BITS-1:0] max_x_s1, max_y_s1, max_z_s1;

	// Each stage advances when it is empty or the stage after it advances.
	assign out_adv  = !out_valid_q || !out_stall;
	assign s2_adv   = !s2_valid_s2 || out_adv;
	assign s1_adv   = !s1_valid_s1 || s2_adv;
	assign in_stall = !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	// A load only lands when the test in stage one moves on at the same
	// edge, so that test has already captured its products from the old store.
	assign load_wr = in_acc && (req_type == REQ_LOAD) && (32'(plane_index) < NUM_PLANES);

	always_comb begin
		wr_plane.nx     = plane_nx;
		wr_plane.ny     = plane_ny;
		wr_plane.nz     = plane_nz;
		wr_plane.offset = plane_offset;
	end

	aabbfc_plane_store #(
		.NUM_PLANES (NUM_PLANES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (load_wr),
		.wr_idx   (plane_index),
		.wr_plane (wr_plane),
		.planes   (planes)
	);

	// Stage one: hold the box of an accepted test.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_s1 <= in_acc && (req_type == REQ_TEST);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			min_x_s1 <= box_min_x;
			min_y_s1 <= box_min_y;
			min_z_s1 <= box_min_z;
			max_x_s1 <= box_max_x;
			max_y_s1 <= box_max_y;
			max_z_s1 <= box_max_z;
		end
	end

	// Stage two: per-plane product registers live in the evaluators.
	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		aabbfc_plane_eval #(
			.COORD_BITS (COORD_BITS)
		) u_eval (
			.clk     (clk),
			.en      (s1_valid_s1 && s2_adv),
			.plane   (planes[p]),
			.min_x   (min_x_s1),
			.min_y   (min_y_s1),
			.min_z   (min_z_s1),
			.max_x   (max_x_s1),
			.max_y   (max_y_s1),
			.max_z   (max_z_s1),
			.outside (outside[p])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else if (s2_adv) begin
			s2_valid_s2 <= s1_valid_s1;
		end
	end

	// Result register: visible only if no plane puts the box outside.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= s2_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && s2_valid_s2) begin
			visible_q <= ~|outside;
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;

`ifndef SYNTHESIS
	a_empty_s1_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_s1 |-> !in_stall)
		else $error("input stalled with stage one empty");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && s2_adv) |=> s2_valid_s2)
		else $error("test lost between stage one and stage two");

	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !s2_valid_s2) |=> !out_valid)
		else $error("result repeated after being taken");

	a_test_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && req_type == REQ_TEST) |=> s1_valid_s1)
		else $error("accepted test missing from stage one");
`endif

endmodule

>>> rtl/core/aabbfc_plane_store.sv
module aabbfc_plane_store #(
	parameter int NUM_PLANES = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [aabbfc_pkg::IDX_W-1:0]     wr_idx,
	input  aabbfc_pkg::plane_t               wr_plane,
	output aabbfc_pkg::plane_t               planes [NUM_PLANES]
);
	import aabbfc_pkg::*;

	plane_t planes_q [NUM_PLANES];

	// cleared planes have zero normal and offset, so they always pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				planes_q[p] <= '0;
			end
		end else if (wr_en) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				if (32'(wr_idx) == p) begin
					planes_q[p] <= wr_plane;
				end
			end
		end
	end

	assign planes = planes_q;

endmodule

>>> rtl/core/aabbfc_plane_eval.sv
module aabbfc_plane_eval #(
	parameter int COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          en,
	input  aabbfc_pkg::plane_t            plane,
	input  logic signed [COORD_BITS-1:0]  min_x,
	input  logic signed [COORD_BITS-1:0]  min_y,
	input  logic signed [COORD_BITS-1:0]  min_z,
	input  logic signed [COORD_BITS-1:0]  max_x,
	input  logic signed [COORD_BITS-1:0]  max_y,
	input  logic signed [COORD_BITS-1:0]  max_z,
	output logic                          outside
);
	import aabbfc_pkg::*;

	localparam int PROD_W = NORM_W + COORD_BITS;
	localparam int SUM_W  = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 2;

	logic signed [COORD_BITS-1:0] cx, cy, cz;
	logic signed [PROD_W-1:0]     px_s2, py_s2, pz_s2;
	logic signed [OFFS_W-1:0]     offs_s2;
	logic signed [SUM_W-1:0]      sum;

	// positive vertex: max where the normal component is non-negative
	always_comb begin
		cx = plane.nx[NORM_W-1] ? min_x : max_x;
		cy = plane.ny[NORM_W-1] ? min_y : max_y;
		cz = plane.nz[NORM_W-1] ? min_z : max_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2   <= PROD_W'(plane.nx * cx);
			py_s2   <= PROD_W'(plane.ny * cy);
			pz_s2   <= PROD_W'(plane.nz * cz);
			offs_s2 <= plane.offset;
		end
	end

	assign sum = SUM_W'(px_s2) + SUM_W'(py_s2) + SUM_W'(pz_s2) + SUM_W'(offs_s2);
	assign outside = sum[SUM_W-1];

endmodule

>>> tb/aabb_frustum_cull_top_tb.sv
`timescale 1ns / 100ps

module aabb_frustum_cull_top_tb;

	import aabbfc_pkg::*;

	localparam int     N_PLANES    = 6;
	localparam int     C_BITS      = 24;
	localparam int     CMIN        = -(1 << (C_BITS - 1));
	localparam int     CMAX        = (1 << (C_BITS - 1)) - 1;
	localparam longint OFFS_MIN    = -64'sd549755813888;
	localparam longint OFFS_MAX    = 64'sd549755813887;
	localparam int     RAND_ITEMS  = 1900;
	localparam int     HOLD_CYCLES = 300;
	localparam int     DOG_LIMIT   = 2000;
	localparam int     DRAIN       = 12;

	// One request as the sender sees it; box fields ride along on loads and
	// plane fields on tests, the block ignores them there.
	typedef struct packed {
		logic                     kind;
		logic [IDX_W-1:0]         slot;
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic signed [OFFS_W-1:0] offs;
		logic signed [C_BITS-1:0] lo_x;
		logic signed [C_BITS-1:0] lo_y;
		logic signed [C_BITS-1:0] lo_z;
		logic signed [C_BITS-1:0] hi_x;
		logic signed [C_BITS-1:0] hi_y;
		logic signed [C_BITS-1:0] hi_z;
	} cull_req_t;

	// Directed row: want is the typed-in flag, or -1 to take the predictor's.
	typedef struct {
		cull_req_t req;
		int        want;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     req_type;
	logic [IDX_W-1:0]         plane_index;
	logic signed [NORM_W-1:0] plane_nx;
	logic signed [NORM_W-1:0] plane_ny;
	logic signed [NORM_W-1:0] plane_nz;
	logic signed [OFFS_W-1:0] plane_offset;
	logic signed [C_BITS-1:0] box_min_x;
	logic signed [C_BITS-1:0] box_min_y;
	logic signed [C_BITS-1:0] box_min_z;
	logic signed [C_BITS-1:0] box_max_x;
	logic signed [C_BITS-1:0] box_max_y;
	logic signed [C_BITS-1:0] box_max_z;
	logic                     out_valid;
	logic                     out_stall;
	logic                     visible;

	// Shadow copy of the plane store, updated at the edge each load is taken.
	plane_t   shadow_planes[N_PLANES];
	logic     vis_expect_q[$];
	dir_row_t dir_tab[$];

	int unsigned fail_count;
	int unsigned n_loads, n_dropped, n_tests, n_vis, n_culled;
	int unsigned idle_cycles;
	bit          held_off;
	logic        want_vis;

	aabb_frustum_cull_top #(
		.NUM_PLANES(N_PLANES),
		.COORD_BITS(C_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.plane_index(plane_index),
		.plane_nx(plane_nx),
		.plane_ny(plane_ny),
		.plane_nz(plane_nz),
		.plane_offset(plane_offset),
		.box_min_x(box_min_x),
		.box_min_y(box_min_y),
		.box_min_z(box_min_z),
		.box_max_x(box_max_x),
		.box_max_y(box_max_y),
		.box_max_z(box_max_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.visible(visible)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Positive-vertex term for one axis: a negative normal component takes the
	// min bound, zero or positive takes the max. Exact in 64 bits.
	function automatic longint corner_term(input logic signed [NORM_W-1:0] n,
			input logic signed [C_BITS-1:0] lo, input logic signed [C_BITS-1:0] hi);
		longint c;
		c = (n < 0) ? longint'(lo) : longint'(hi);
		return longint'(n) * c;
	endfunction

	// A box survives unless some stored plane puts its far corner behind it.
	function automatic logic box_visible(input cull_req_t r);
		longint acc;
		for (int i = 0; i < N_PLANES; i++) begin
			acc = longint'(shadow_planes[i].offset)
				+ corner_term(shadow_planes[i].nx, r.lo_x, r.hi_x)
				+ corner_term(shadow_planes[i].ny, r.lo_y, r.hi_y)
				+ corner_term(shadow_planes[i].nz, r.lo_z, r.hi_z);
			if (acc < 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Apply an accepted request: write the shadow store, or queue the flag.
	function automatic void take_request(input cull_req_t r, input int want);
		logic v;
		if (r.kind == REQ_LOAD) begin
			if (r.slot < N_PLANES) begin
				shadow_planes[r.slot].nx     = r.nx;
				shadow_planes[r.slot].ny     = r.ny;
				shadow_planes[r.slot].nz     = r.nz;
				shadow_planes[r.slot].offset = r.offs;
				n_loads++;
			end else begin
				n_dropped++;
			end
		end else begin
			v = box_visible(r);
			vis_expect_q.push_back((want < 0) ? v : want[0]);
			n_tests++;
		end
	endfunction

	function automatic void add_plane(input int slot, input int nx, input int ny, input int nz,
			input longint offs);
		dir_row_t row;
		row.req      = '0;
		row.req.kind = REQ_LOAD;
		row.req.slot = slot[IDX_W-1:0];
		row.req.nx   = nx[NORM_W-1:0];
		row.req.ny   = ny[NORM_W-1:0];
		row.req.nz   = nz[NORM_W-1:0];
		row.req.offs = offs[OFFS_W-1:0];
		row.want     = -1;
		dir_tab.push_back(row);
	endfunction

	function automatic void add_box(input int lx, input int ly, input int lz,
			input int hx, input int hy, input int hz, input int want);
		dir_row_t row;
		row.req      = '0;
		row.req.kind = REQ_TEST;
		row.req.lo_x = lx[C_BITS-1:0];
		row.req.lo_y = ly[C_BITS-1:0];
		row.req.lo_z = lz[C_BITS-1:0];
		row.req.hi_x = hx[C_BITS-1:0];
		row.req.hi_y = hy[C_BITS-1:0];
		row.req.hi_z = hz[C_BITS-1:0];
		row.want     = want;
		dir_tab.push_back(row);
	endfunction

	// One axis of a random box: full range, small, or an extreme; mostly
	// ordered, now and then left inverted.
	function automatic void random_span(output logic signed [C_BITS-1:0] lo,
			output logic signed [C_BITS-1:0] hi);
		logic signed [C_BITS-1:0] a, b, t;
		int mode;
		mode = $urandom_range(0, 3);
		a = C_BITS'($urandom);
		b = C_BITS'($urandom);
		if (mode == 1 || mode == 2) begin
			a = {{(C_BITS-12){a[11]}}, a[11:0]};
			b = {{(C_BITS-12){b[11]}}, b[11:0]};
		end else if (mode == 3) begin
			case ($urandom_range(0, 3))
				0: a = C_BITS'(CMIN);
				1: a = C_BITS'(CMAX);
				2: a = '0;
				default: a = '1;
			endcase
		end
		if ($urandom_range(0, 9) != 0 && a > b) begin
			t = a;
			a = b;
			b = t;
		end
		lo = a;
		hi = b;
	endfunction

	function automatic cull_req_t random_request();
		cull_req_t   r;
		logic [63:0] bits;
		int          flavor;
		// fill every field with noise first, then shape the ones that count
		r.kind = REQ_TEST;
		r.slot = IDX_W'($urandom);
		r.nx   = NORM_W'($urandom);
		r.ny   = NORM_W'($urandom);
		r.nz   = NORM_W'($urandom);
		bits   = {$urandom, $urandom};
		r.offs = bits[OFFS_W-1:0];
		r.lo_x = C_BITS'($urandom);
		r.lo_y = C_BITS'($urandom);
		r.lo_z = C_BITS'($urandom);
		r.hi_x = C_BITS'($urandom);
		r.hi_y = C_BITS'($urandom);
		r.hi_z = C_BITS'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			r.kind = REQ_LOAD;
			flavor = $urandom_range(0, 19);
			if (flavor < 8) begin
				// neutral plane: zero normal, non-negative offset, always passes
				r.nx   = '0;
				r.ny   = '0;
				r.nz   = '0;
				r.offs = {4'b0, bits[35:0]};
			end else begin
				if ($urandom_range(0, 5) == 0) r.nx = '0;
				if ($urandom_range(0, 5) == 0) r.ny = '0;
				if ($urandom_range(0, 5) == 0) r.nz = '0;
				if (flavor < 15)
					r.offs = {{(OFFS_W-37){bits[36]}}, bits[36:0]};
			end
		end else begin
			random_span(r.lo_x, r.hi_x);
			random_span(r.lo_y, r.hi_y);
			random_span(r.lo_z, r.hi_z);
		end
		return r;
	endfunction

	// Offer one request and hold it until the block takes it.
	task automatic issue(input cull_req_t r, input int want);
		in_valid     <= 1'b1;
		req_type     <= r.kind;
		plane_index  <= r.slot;
		plane_nx     <= r.nx;
		plane_ny     <= r.ny;
		plane_nz     <= r.nz;
		plane_offset <= r.offs;
		box_min_x    <= r.lo_x;
		box_min_y    <= r.lo_y;
		box_min_z    <= r.lo_z;
		box_max_x    <= r.hi_x;
		box_max_y    <= r.hi_y;
		box_max_z    <= r.hi_z;
		do @(posedge clk); while (in_stall);
		take_request(r, want);
	endtask

	// Drop valid for a gap set by n; zero leaves the burst running.
	task automatic pause_sender(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		cull_req_t   r;
		int          k;
		int          burst;
		int unsigned n_rand;
		in_valid     = 1'b0;
		req_type     = REQ_LOAD;
		plane_index  = '0;
		plane_nx     = '0;
		plane_ny     = '0;
		plane_nz     = '0;
		plane_offset = '0;
		box_min_x    = '0;
		box_min_y    = '0;
		box_min_z    = '0;
		box_max_x    = '0;
		box_max_y    = '0;
		box_max_z    = '0;
		arst_n       = 1'b0;
		fail_count   = 0;
		n_loads      = 0;
		n_dropped    = 0;
		n_tests      = 0;
		n_vis        = 0;
		n_culled     = 0;
		n_rand       = 0;
		for (k = 0; k < N_PLANES; k++)
			shadow_planes[k] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fresh store: every plane is zero, so any box passes, inverted too.
		add_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1);
		add_box(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1);
		// Loads past the last slot must be dropped without touching the store.
		add_plane(6, 0, 0, 0, -1);
		add_plane(7, 0, 0, 0, OFFS_MIN);
		add_box(0, 0, 0, 0, 0, 0, 1);
		// A negative offset alone culls everything; a zero sum does not.
		add_plane(0, 0, 0, 0, -1);
		add_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);
		add_plane(0, 0, 0, 0, 0);
		add_box(-7, -7, -7, 7, 7, 7, 1);
		add_plane(5, 0, 0, 0, OFFS_MIN);
		add_box(1, 2, 3, 4, 5, 6, 0);
		add_plane(5, 0, 0, 0, OFFS_MAX);
		// Extreme normals, a zero component, and the offset extremes.
		add_plane(1, 32767, -32768, 0, 0);
		add_box(-5, -5, -5, 5, 5, 5, -1);
		add_box(-10, 3, CMIN, -2, 8, CMAX, -1);
		add_plane(2, -32768, -32768, -32768, OFFS_MAX);
		add_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, -1);
		add_plane(3, 32767, 32767, 32767, OFFS_MIN);
		add_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, -1);
		add_box(CMIN, CMIN, CMIN, 0, 0, 0, -1);
		add_box(10, 10, 10, -10, -10, -10, -1);
		add_plane(4, 0, 0, -1, 0);
		add_box(CMIN, CMIN, -1, CMAX, CMAX, CMAX, -1);
		add_box(CMAX, CMAX, 1, CMIN, CMIN, -1, -1);

		// Walk the table, with a short gap after every few rows.
		for (k = 0; k < dir_tab.size(); k++) begin
			issue(dir_tab[k].req, dir_tab[k].want);
			if (k % 4 == 3)
				pause_sender($urandom_range(1, 3));
		end

		// Random part: bursts of requests with gaps between them; some bursts
		// run back to back. Dropped loads do not count toward the total.
		burst = $urandom_range(1, 24);
		while (n_rand < RAND_ITEMS) begin
			r = random_request();
			issue(r, -1);
			if (r.kind == REQ_TEST || r.slot < N_PLANES)
				n_rand++;
			burst = burst - 1;
			if (burst == 0) begin
				pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
				burst = $urandom_range(1, 24);
			end
		end
		in_valid <= 1'b0;

		// Wait out the pipeline; the watchdog bounds this.
		while (vis_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d plane loads (%0d out-of-range dropped), %0d box tests",
			n_loads, n_dropped, n_tests);
		$display("results: %0d visible, %0d culled; long receiver hold-off %s",
			n_vis, n_culled, held_off ? "done" : "not reached");
		if (fail_count == 0) begin
			$display("aabb_frustum_cull_top_tb: clean");
		end else begin
			$display("aabb_frustum_cull_top_tb: errors");
		end
		$finish;
	end

	// Receiver: stretches of no stall, light stall, heavy stall and toggling.
	// Once, well into the run, hold off for a long stretch so the pipeline
	// fills and in_stall must rise while the sender keeps offering.
	initial begin : stall_gen
		int span;
		int mode;
		int k;
		out_stall = 1'b0;
		held_off  = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held_off && (n_vis + n_culled) >= 200) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end
			span = $urandom_range(8, 60);
			mode = $urandom_range(0, 3);
			for (k = 0; k < span; k++) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= k[0];
				endcase
				@(posedge clk);
			end
		end
	end

	// Check every accepted result against the oldest expected flag.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (vis_expect_q.size() == 0) begin
				$error("visible: no box test waiting, actual %0b", visible);
				fail_count++;
			end else begin
				want_vis = vis_expect_q.pop_front();
				if (visible !== want_vis) begin
					$error("visible: expected %0b, actual %0b", want_vis, visible);
					fail_count++;
				end
				if (want_vis)
					n_vis++;
				else
					n_culled++;
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves a request.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= DOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				idle_cycles, vis_expect_q.size());
			$display("aabb_frustum_cull_top_tb: errors");
			$finish;
		end
	end

	initial idle_cycles = 0;

endmodule

>>> aabb_frustum_cull_top.f
rtl/core/aabbfc_pkg.sv
rtl/core/aabbfc_plane_store.sv
rtl/core/aabbfc_plane_eval.sv
rtl/core/aabb_frustum_cull_top.sv
tb/aabb_frustum_cull_top_tb.sv
